>>> hw/rtl/rtd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtd_pkg;

  // operation codes
  localparam logic [2:0] OP_SCHEDULE = 3'd0;
  localparam logic [2:0] OP_FINISH_DONE = 3'd1;
  localparam logic [2:0] OP_FINISH_RESUBMIT = 3'd2;
  localparam logic [2:0] OP_DISPATCH = 3'd3;
  localparam logic [2:0] OP_COUNT = 3'd4;

  // result kinds
  localparam logic [2:0] KIND_STARTED = 3'd0;
  localparam logic [2:0] KIND_RETIRED = 3'd1;
  localparam logic [2:0] KIND_COUNT = 3'd2;
  localparam logic [2:0] KIND_ACK = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FIN,
    S_SCAN,
    S_PICK,
    S_CNT
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/rtd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rtd_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  operation;
  logic        [3:0]  task_id;
  logic        [31:0] resource_mask;
  logic signed [31:0] delay_ms;
  logic        [30:0] repeat_ms;
  logic               single_shot;
  logic        [31:0] now_ms;

  modport source (
    output valid, operation, task_id, resource_mask, delay_ms, repeat_ms,
           single_shot, now_ms,
    input  ready
  );
  modport sink (
    input  valid, operation, task_id, resource_mask, delay_ms, repeat_ms,
           single_shot, now_ms,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/rtd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rtd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  task_id_res;
  logic [4:0]  count;
  logic [31:0] free_resources;
  logic        last;

  modport source (
    output valid, kind, task_id_res, count, free_resources, last,
    input  ready
  );
  modport sink (
    input  valid, kind, task_id_res, count, free_resources, last,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/resource_aware_task_dispatcher_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Timed task dispatcher with a resource mask per task. Slot data (mask, due
// time, interval, single-shot flag, order tag) sits in one single-port-read
// memory; valid and running bits are flip-flops. A count query walks the
// memory once. A dispatch pass selects the oldest unvisited waiting task
// with one full walk of the memory per visited task, through the single
// memory read port. Results leave through an output register, and each
// result waits there until transferred before the next one is made.
module resource_aware_task_dispatcher_unit #(
  parameter int MAX_TASKS = 16,
  parameter int RES_BITS  = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  rtd_in_if.sink   in_chan,
  rtd_out_if.source out_chan
);
  import rtd_pkg::*;

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int EW = RES_BITS + 96;
  localparam logic [CW-1:0] N_C = CW'(MAX_TASKS);
  localparam logic [8:0] N_9 = 9'(MAX_TASKS);

  state_t state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic [3:0] id_r, id_nxt;
  logic [RES_BITS-1:0] rmask_r, rmask_nxt;
  logic [31:0] delay_r, delay_nxt;
  logic [30:0] repeat_r, repeat_nxt;
  logic once_r, once_nxt;
  logic [31:0] now_r, now_nxt;

  logic [MAX_TASKS-1:0] valid_r, valid_nxt;
  logic [MAX_TASKS-1:0] running_r, running_nxt;
  logic [MAX_TASKS-1:0] seen_r, seen_nxt;
  logic [RES_BITS-1:0] free_r, free_nxt;
  logic [31:0] oc_r, oc_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic dvld_r, dvld_nxt;
  logic [IW-1:0] didx_r, didx_nxt;
  logic best_found_r, best_found_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic [31:0] best_key_r, best_key_nxt;
  logic [RES_BITS-1:0] best_mask_r, best_mask_nxt;
  logic [31:0] best_due_r, best_due_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic [3:0] tid_r, tid_nxt;
  logic [4:0] ocnt_r, ocnt_nxt;
  logic [31:0] ofree_r, ofree_nxt;
  logic last_r, last_nxt;

  // memory ports
  logic mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  rtd_ram #(.WIDTH(EW), .DEPTH(MAX_TASKS)) u_slots (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // entry fields
  logic [RES_BITS-1:0] d_mask;
  logic [31:0] d_due, d_order;
  logic [30:0] d_int;
  logic d_once;
  assign d_mask  = mem_rdata[EW-1 -: RES_BITS];
  assign d_due   = mem_rdata[95:64];
  assign d_int   = mem_rdata[63:33];
  assign d_once  = mem_rdata[32];
  assign d_order = mem_rdata[31:0];

  // width adapters
  logic [RES_BITS+31:0] rm_ext;
  logic [IW+3:0] sid_ext, bi_ext;
  logic [CW+4:0] cnt_ext;
  logic [IW-1:0] sid;
  logic id_ok;
  assign rm_ext  = {{RES_BITS{1'b0}}, in_chan.resource_mask};
  assign sid_ext = {{IW{1'b0}}, id_r};
  assign sid     = sid_ext[IW-1:0];
  assign bi_ext  = {4'b0, best_idx_r};
  assign cnt_ext = {5'b0, count_r};
  assign id_ok   = ({5'b0, id_r} < N_9);

  logic can_emit;
  assign can_emit = !out_valid_r || out_chan.ready;

  logic emit;
  logic [2:0] e_kind;
  logic [3:0] e_tid;
  logic [4:0] e_cnt;
  logic [RES_BITS-1:0] e_free;
  logic [RES_BITS+31:0] efree_ext;
  assign efree_ext = {32'b0, e_free};

  logic [31:0] key, age;
  logic cand;
  assign key  = d_order - oc_r;
  assign cand = valid_r[didx_r] && !running_r[didx_r] && !seen_r[didx_r];
  assign age  = now_r - best_due_r;

  // next state and datapath
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    rmask_nxt      = rmask_r;
    delay_nxt      = delay_r;
    repeat_nxt     = repeat_r;
    once_nxt       = once_r;
    now_nxt        = now_r;
    valid_nxt      = valid_r;
    running_nxt    = running_r;
    seen_nxt       = seen_r;
    free_nxt       = free_r;
    oc_nxt         = oc_r;
    cnt_nxt        = cnt_r;
    dvld_nxt       = dvld_r;
    didx_nxt       = didx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_key_nxt   = best_key_r;
    best_mask_nxt  = best_mask_r;
    best_due_nxt   = best_due_r;
    count_nxt      = count_r;
    mem_we         = 1'b0;
    mem_waddr      = sid;
    mem_wdata      = {d_mask, d_due, d_int, d_once, d_order};
    mem_re         = 1'b0;
    mem_raddr      = sid;
    emit           = 1'b0;
    e_kind         = KIND_ACK;
    e_tid          = id_r;
    e_cnt          = 5'd0;
    e_free         = free_r;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          op_nxt     = in_chan.operation;
          id_nxt     = in_chan.task_id;
          rmask_nxt  = rm_ext[RES_BITS-1:0];
          delay_nxt  = in_chan.delay_ms;
          repeat_nxt = in_chan.repeat_ms;
          once_nxt   = in_chan.single_shot;
          now_nxt    = in_chan.now_ms;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        if (op_r == OP_SCHEDULE) begin
          if (can_emit) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
            if (!id_ok || valid_r[sid]) begin
              e_kind = KIND_ERROR;
            end else begin
              mem_we           = 1'b1;
              mem_wdata        = {rmask_r, now_r + delay_r, repeat_r, once_r, oc_r};
              valid_nxt[sid]   = 1'b1;
              running_nxt[sid] = 1'b0;
              oc_nxt           = oc_r + 32'd1;
            end
          end
        end else if (op_r == OP_FINISH_DONE || op_r == OP_FINISH_RESUBMIT) begin
          if (!id_ok || !valid_r[sid] || !running_r[sid]) begin
            if (can_emit) begin
              emit      = 1'b1;
              e_kind    = KIND_ERROR;
              state_nxt = S_IDLE;
            end
          end else begin
            mem_re    = 1'b1;
            state_nxt = S_FIN;
          end
        end else if (op_r == OP_DISPATCH || op_r == OP_COUNT) begin
          seen_nxt       = '0;
          cnt_nxt        = '0;
          dvld_nxt       = 1'b0;
          best_found_nxt = 1'b0;
          count_nxt      = '0;
          state_nxt      = (op_r == OP_DISPATCH) ? S_SCAN : S_CNT;
        end else begin
          if (can_emit) begin
            emit      = 1'b1;
            e_kind    = KIND_ERROR;
            state_nxt = S_IDLE;
          end
        end
      end

      // slot data is back: release and re-arm or retire
      S_FIN: begin
        if (can_emit) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          free_nxt  = free_r | d_mask;
          e_free    = free_r | d_mask;
          if (op_r == OP_FINISH_RESUBMIT || !d_once) begin
            mem_we           = 1'b1;
            mem_wdata        = {d_mask,
                                (op_r == OP_FINISH_RESUBMIT) ? now_r : now_r + {1'b0, d_int},
                                d_int, d_once, oc_r};
            running_nxt[sid] = 1'b0;
            oc_nxt           = oc_r + 32'd1;
          end else begin
            e_kind           = KIND_RETIRED;
            valid_nxt[sid]   = 1'b0;
            running_nxt[sid] = 1'b0;
          end
        end
      end

      // walk all slots for the oldest unvisited waiting task
      S_SCAN: begin
        if (cnt_r < N_C) begin
          mem_re    = 1'b1;
          mem_raddr = cnt_r[IW-1:0];
          didx_nxt  = cnt_r[IW-1:0];
          cnt_nxt   = cnt_r + 1'b1;
          dvld_nxt  = 1'b1;
        end else begin
          dvld_nxt = 1'b0;
        end
        if (dvld_r && cand && (!best_found_r || key < best_key_r)) begin
          best_found_nxt = 1'b1;
          best_idx_nxt   = didx_r;
          best_key_nxt   = key;
          best_mask_nxt  = d_mask;
          best_due_nxt   = d_due;
        end
        if (cnt_r == N_C && !dvld_r) begin
          state_nxt = S_PICK;
        end
      end

      // start the selected task if it fits and is due
      S_PICK: begin
        if (!best_found_r) begin
          if (can_emit) begin
            emit      = 1'b1;
            e_tid     = 4'd0;
            state_nxt = S_IDLE;
          end
        end else if ((best_mask_r & free_r) == best_mask_r && !age[31]) begin
          if (can_emit) begin
            emit                    = 1'b1;
            e_kind                  = KIND_STARTED;
            e_tid                   = bi_ext[3:0];
            e_free                  = free_r & ~best_mask_r;
            free_nxt                = free_r & ~best_mask_r;
            running_nxt[best_idx_r] = 1'b1;
            seen_nxt[best_idx_r]    = 1'b1;
            cnt_nxt                 = '0;
            dvld_nxt                = 1'b0;
            best_found_nxt          = 1'b0;
            state_nxt               = S_SCAN;
          end
        end else begin
          seen_nxt[best_idx_r] = 1'b1;
          cnt_nxt              = '0;
          dvld_nxt             = 1'b0;
          best_found_nxt       = 1'b0;
          state_nxt            = S_SCAN;
        end
      end

      // count valid slots whose mask holds every asked resource
      S_CNT: begin
        if (cnt_r < N_C) begin
          mem_re    = 1'b1;
          mem_raddr = cnt_r[IW-1:0];
          didx_nxt  = cnt_r[IW-1:0];
          cnt_nxt   = cnt_r + 1'b1;
          dvld_nxt  = 1'b1;
        end else begin
          dvld_nxt = 1'b0;
        end
        if (dvld_r && valid_r[didx_r] && (d_mask & rmask_r) == rmask_r) begin
          count_nxt = count_r + 1'b1;
        end
        if (cnt_r == N_C && !dvld_r && can_emit) begin
          emit      = 1'b1;
          e_kind    = KIND_COUNT;
          e_tid     = 4'd0;
          e_cnt     = cnt_ext[4:0];
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    tid_nxt       = tid_r;
    ocnt_nxt      = ocnt_r;
    ofree_nxt     = ofree_r;
    last_nxt      = last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = e_kind;
      tid_nxt       = e_tid;
      ocnt_nxt      = e_cnt;
      ofree_nxt     = efree_ext[31:0];
      last_nxt      = (e_kind != KIND_STARTED);
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      running_r   <= '0;
      free_r      <= '1;
      oc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      running_r   <= running_nxt;
      free_r      <= free_nxt;
      oc_r        <= oc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    rmask_r      <= rmask_nxt;
    delay_r      <= delay_nxt;
    repeat_r     <= repeat_nxt;
    once_r       <= once_nxt;
    now_r        <= now_nxt;
    seen_r       <= seen_nxt;
    cnt_r        <= cnt_nxt;
    dvld_r       <= dvld_nxt;
    didx_r       <= didx_nxt;
    best_found_r <= best_found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_key_r   <= best_key_nxt;
    best_mask_r  <= best_mask_nxt;
    best_due_r   <= best_due_nxt;
    count_r      <= count_nxt;
    kind_r       <= kind_nxt;
    tid_r        <= tid_nxt;
    ocnt_r       <= ocnt_nxt;
    ofree_r      <= ofree_nxt;
    last_r       <= last_nxt;
  end

  assign in_chan.ready           = (state_r == S_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.kind           = kind_r;
  assign out_chan.task_id_res    = tid_r;
  assign out_chan.count          = ocnt_r;
  assign out_chan.free_resources = ofree_r;
  assign out_chan.last           = last_r;

endmodule

`default_nettype wire

>>> hw/rtl/rtd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sim/rtd_tb_ifs.sv
`timescale 1ns / 1ps

// the block's channel interfaces are reused as they stand in the rtl tree;
// this file carries the scoreboard result record shared by the bench
package rtd_tb_pkg;
  import rtd_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  task_id_res;
    logic [4:0]  count;
    logic [31:0] free_resources;
    logic        last;
  } dispatch_result_t;
endpackage

>>> sim/resource_aware_task_dispatcher_unit_test.sv
`timescale 1ns / 1ps

module resource_aware_task_dispatcher_unit_test;
  import rtd_pkg::*;
  import rtd_tb_pkg::*;

  localparam int NUM_SLOTS = 16;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count = 0;

  always #4 clk = ~clk;

  rtd_in_if  in_chan ();
  rtd_out_if out_chan ();

  resource_aware_task_dispatcher_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source)
  );

  // scoreboard: mirror of the slot table and queue of pending results
  class dispatch_scoreboard;
    bit               valid_q[NUM_SLOTS];
    bit               running_q[NUM_SLOTS];
    logic [31:0]      mask_q[NUM_SLOTS];
    logic [31:0]      due_q[NUM_SLOTS];
    logic [30:0]      interval_q[NUM_SLOTS];
    bit               once_q[NUM_SLOTS];
    logic [31:0]      tag_q[NUM_SLOTS];
    logic [31:0]      free_res;
    logic [31:0]      tag_counter;
    dispatch_result_t pending[$];

    function void clear();
      foreach (valid_q[i]) begin
        valid_q[i] = 1'b0;
        running_q[i] = 1'b0;
      end
      free_res = '1;
      tag_counter = '0;
      pending.delete();
    endfunction

    function void push(logic [2:0] k, logic [3:0] id, logic [4:0] c, bit l);
      dispatch_result_t r;
      r.kind = k;
      r.task_id_res = id;
      r.count = c;
      r.free_resources = free_res;
      r.last = l;
      pending = {pending, r};
    endfunction

    function void arm(int id, logic [31:0] due);
      valid_q[id] = 1'b1;
      running_q[id] = 1'b0;
      due_q[id] = due;
      tag_q[id] = tag_counter;
      tag_counter = tag_counter + 1;
    endfunction

    function void note_input(logic [2:0] op, logic [3:0] id, logic [31:0] rmask,
                             logic [31:0] delay, logic [30:0] rep, bit once,
                             logic [31:0] now);
      bit          seen[NUM_SLOTS];
      int          best;
      logic [31:0] best_key, key, diff;
      int          cnt;
      case (op)
        OP_SCHEDULE: begin
          if (valid_q[id]) begin
            push(KIND_ERROR, id, 0, 1);
          end else begin
            mask_q[id] = rmask;
            interval_q[id] = rep;
            once_q[id] = once;
            arm(id, now + delay);
            push(KIND_ACK, id, 0, 1);
          end
        end
        OP_FINISH_DONE, OP_FINISH_RESUBMIT: begin
          if (!valid_q[id] || !running_q[id]) begin
            push(KIND_ERROR, id, 0, 1);
          end else begin
            free_res = free_res | mask_q[id];
            if (op == OP_FINISH_RESUBMIT) begin
              arm(id, now);
              push(KIND_ACK, id, 0, 1);
            end else if (once_q[id]) begin
              valid_q[id] = 1'b0;
              running_q[id] = 1'b0;
              push(KIND_RETIRED, id, 0, 1);
            end else begin
              arm(id, now + {1'b0, interval_q[id]});
              push(KIND_ACK, id, 0, 1);
            end
          end
        end
        OP_DISPATCH: begin
          foreach (seen[i]) seen[i] = 1'b0;
          for (int p = 0; p < NUM_SLOTS; p++) begin
            best = -1;
            best_key = '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (seen[i] || !valid_q[i] || running_q[i]) continue;
              key = tag_q[i] - tag_counter;
              if (best < 0 || key < best_key) begin
                best = i;
                best_key = key;
              end
            end
            if (best < 0) break;
            seen[best] = 1'b1;
            diff = now - due_q[best];
            if ((mask_q[best] & free_res) == mask_q[best] && !diff[31]) begin
              free_res = free_res & ~mask_q[best];
              running_q[best] = 1'b1;
              push(KIND_STARTED, best[3:0], 0, 0);
            end
          end
          push(KIND_ACK, 0, 0, 1);
        end
        OP_COUNT: begin
          cnt = 0;
          for (int i = 0; i < NUM_SLOTS; i++)
            if (valid_q[i] && (mask_q[i] & rmask) == rmask) cnt++;
          push(KIND_COUNT, 0, cnt[4:0], 1);
        end
        default: push(KIND_ERROR, id, 0, 1);
      endcase
    endfunction

    function int check_result(dispatch_result_t got);
      dispatch_result_t exp;
      int bad;
      bad = 0;
      if (pending.size() == 0) begin
        $error("result with nothing pending: kind %0d", got.kind);
        return 1;
      end
      exp = pending.pop_front();
      if (got.kind !== exp.kind) begin
        $error("kind: expected %0d, actual %0d", exp.kind, got.kind);
        bad = 1;
      end
      if (got.task_id_res !== exp.task_id_res) begin
        $error("task_id_res: expected %0d, actual %0d", exp.task_id_res, got.task_id_res);
        bad = 1;
      end
      if (got.count !== exp.count) begin
        $error("count: expected %0d, actual %0d", exp.count, got.count);
        bad = 1;
      end
      if (got.free_resources !== exp.free_resources) begin
        $error("free_resources: expected %h, actual %h", exp.free_resources,
               got.free_resources);
        bad = 1;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d, actual %0d", exp.last, got.last);
        bad = 1;
      end
      return bad;
    endfunction
  endclass

  dispatch_scoreboard board;
  logic [31:0] clock_ms = 32'd100;
  int          idle_pct = 31;
  int          idle_cycles = 0;

  // initial input values
  initial begin
    in_chan.valid = 1'b0;
    in_chan.operation = OP_COUNT;
    in_chan.task_id = '0;
    in_chan.resource_mask = '0;
    in_chan.delay_ms = '0;
    in_chan.repeat_ms = '0;
    in_chan.single_shot = 1'b0;
    in_chan.now_ms = '0;
    out_chan.ready = 1'b0;
  end

  // one input transfer, with random gaps before it; valid stays up between
  // back-to-back transfers
  task automatic send_item(logic [2:0] op, logic [3:0] id, logic [31:0] rmask,
                           logic [31:0] delay, logic [30:0] rep, bit once,
                           logic [31:0] now);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.operation <= op;
    in_chan.task_id <= id;
    in_chan.resource_mask <= rmask;
    in_chan.delay_ms <= delay;
    in_chan.repeat_ms <= rep;
    in_chan.single_shot <= once;
    in_chan.now_ms <= now;
    do @(posedge clk); while (!in_chan.ready);
    board.note_input(op, id, rmask, delay, rep, once, now);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // mostly small masks over the low four bits, sometimes a full random word, so that resources conflict often
  function automatic logic [31:0] pick_mask();
    case ($urandom_range(3))
      0: return 32'd0;
      1: return 32'h1 << $urandom_range(3);
      2: return $urandom_range(15);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [3:0] pick_running();
    logic [3:0] c;
    for (int t = 0; t < 8; t++) begin
      c = 4'($urandom_range(15));
      if (board.running_q[c]) return c;
    end
    return 4'($urandom_range(15));
  endfunction

  // result sink with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready)
        fail_count += board.check_result({out_chan.kind, out_chan.task_id_res,
                                          out_chan.count, out_chan.free_resources,
                                          out_chan.last});
      out_chan.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [2:0] op;
    board = new();
    board.clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, busy schedule, idle finish, unknown codes, wrap
    send_item(OP_COUNT, 0, 32'd0, 0, 0, 0, clock_ms);
    send_item(OP_DISPATCH, 0, 0, 0, 0, 0, clock_ms);
    send_item(OP_SCHEDULE, 0, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 0,
              32'hFFFF_FFF0);
    send_item(OP_SCHEDULE, 0, 32'h1, 0, 0, 1, clock_ms);
    send_item(OP_SCHEDULE, 15, 32'h0, 32'sh8000_0000, 31'd0, 1, 32'hFFFF_FFFF);
    send_item(OP_SCHEDULE, 1, 32'h3, -32'sd5, 31'd10, 0, 32'd2);
    send_item(OP_SCHEDULE, 2, 32'h2, 32'sd0, 31'd1, 1, 32'd0);
    send_item(OP_FINISH_DONE, 3, 0, 0, 0, 0, 32'd0);
    send_item(OP_FINISH_RESUBMIT, 1, 0, 0, 0, 0, 32'd0);
    send_item(OP_DISPATCH, 0, 0, 0, 0, 0, 32'd0);
    send_item(OP_DISPATCH, 0, 0, 0, 0, 0, 32'h7FFF_FFF0);
    send_item(OP_COUNT, 0, 32'h1, 0, 0, 0, 0);
    send_item(OP_COUNT, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_item(OP_FINISH_RESUBMIT, 15, 0, 0, 0, 0, 32'd50);
    send_item(OP_FINISH_DONE, 1, 0, 0, 0, 0, 32'd50);
    send_item(OP_FINISH_DONE, 2, 0, 0, 0, 0, 32'd50);
    send_item(3'd5, 7, 0, 0, 0, 0, 0);
    send_item(3'd6, 8, 0, 0, 0, 0, 0);
    send_item(3'd7, 9, 0, 0, 0, 0, 0);
    send_item(OP_DISPATCH, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);

    // sender holds off until the block has drained
    wait_drained();

    // random: mostly schedule / dispatch / finish cycles with moving time
    for (int n = 0; n < 300; n++) begin
      if (n == 100) idle_pct = 0;
      if (n == 160) idle_pct = 31;
      clock_ms = clock_ms + $urandom_range(40);
      if ($urandom_range(19) == 0) clock_ms = $urandom();
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5: op = OP_SCHEDULE;
        6, 7, 8, 9, 10:   op = OP_DISPATCH;
        11, 12, 13:       op = OP_FINISH_DONE;
        14, 15:           op = OP_FINISH_RESUBMIT;
        16, 17:           op = OP_COUNT;
        default:          op = 3'($urandom_range(7));
      endcase
      if (op == OP_FINISH_DONE || op == OP_FINISH_RESUBMIT)
        send_item(op, pick_running(), $urandom(), $urandom(), 31'($urandom()),
                  1'($urandom_range(1)), clock_ms);
      else
        send_item(op, 4'($urandom_range(15)), pick_mask(),
                  ($urandom_range(3) == 0) ? $urandom() : $urandom_range(60) - 20,
                  31'(($urandom_range(3) == 0) ? $urandom() : $urandom_range(50)),
                  1'($urandom_range(1)), clock_ms);
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && board.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
